@@ hw/rtl/pngcs_pkg.sv @@
// Shared types, constants and helpers for the PNG chunk header scanner.
package pngcs_pkg;

  // Scan phases
  localparam logic [2:0] PH_SIG       = 3'd0;
  localparam logic [2:0] PH_IHDR_LEN  = 3'd1;
  localparam logic [2:0] PH_IHDR_TYPE = 3'd2;
  localparam logic [2:0] PH_IHDR_DATA = 3'd3;
  localparam logic [2:0] PH_SKIP      = 3'd4;
  localparam logic [2:0] PH_LEN       = 3'd5;
  localparam logic [2:0] PH_TYPE      = 3'd6;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXIF       = 3'd1;
  localparam logic [2:0] ST_BAD_SIG    = 3'd2;
  localparam logic [2:0] ST_BAD_LEN    = 3'd3;
  localparam logic [2:0] ST_NOT_IHDR   = 3'd4;
  localparam logic [2:0] ST_BAD_COLOUR = 3'd5;
  localparam logic [2:0] ST_TRUNC      = 3'd6;

  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_EXIF = 32'h6558_4966;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

  localparam logic [31:0] IHDR_DATA_LEN = 32'd13;
  localparam logic [3:0]  IHDR_LAST_IDX = 4'd12;
  localparam logic [3:0]  IHDR_COLOUR_IDX = 4'd9;
  localparam logic [32:0] CRC_LEN = 33'd4;
  localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

  localparam logic [7:0] PNG_MAGIC [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  colour_kind;
    logic [2:0]  channel_count;
    logic [31:0] exif_offset;
    logic [31:0] exif_length;
  } scan_result_t;

  // Channel count for a colour type; zero flags an unsupported type.
  function automatic logic [2:0] channels_of(input logic [7:0] kind,
                                             input logic count_alpha);
    logic [2:0] chans;
    case (kind)
      8'd0:       chans = 3'd1;
      8'd4:       chans = 3'd1 + {2'b00, count_alpha};
      8'd2, 8'd3: chans = 3'd3;
      8'd6:       chans = 3'd3 + {2'b00, count_alpha};
      default:    chans = 3'd0;
    endcase
    return chans;
  endfunction

endpackage

@@ hw/rtl/pngcs_in_if.sv @@
// Byte stream channel: one file byte and its end-of-file mark per transfer.
interface pngcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/pngcs_out_if.sv @@
// Result channel: one scan result per file.
interface pngcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [7:0]  colour_kind;
  logic [2:0]  channel_count;
  logic [31:0] exif_offset;
  logic [31:0] exif_length;

  modport source (output valid, output status, output image_width, output image_height,
                  output colour_kind, output channel_count, output exif_offset,
                  output exif_length, input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  input colour_kind, input channel_count, input exif_offset,
                  input exif_length, output ready);
endinterface

@@ hw/rtl/pngcs_core.sv @@
// Per-byte chunk walker: file state registers and the next-state/result logic.
module pngcs_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic                   count_alpha,
  output logic                   emit,
  output pngcs_pkg::scan_result_t res
);
  import pngcs_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic [31:0] file_offset, file_offset_next;
  logic [32:0] skip_rem, skip_rem_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] width_r, width_r_next;
  logic [31:0] height_r, height_r_next;
  logic [7:0]  colour, colour_next;
  logic        sent;

  logic        emit_c;
  logic [2:0]  status_c;
  logic [2:0]  chans_c;
  logic [31:0] xoff_c, xlen_c;
  logic [31:0] len_shift, type_shift;
  logic [32:0] skip_dec;

  assign len_shift  = {chunk_len[23:0], data_byte};
  assign type_shift = {chunk_tag[23:0], data_byte};
  assign skip_dec   = (skip_rem != 33'd0) ? skip_rem - 33'd1 : skip_rem;

  always_comb begin
    phase_next       = phase;
    idx_next         = idx;
    file_offset_next = (file_offset == OFFSET_MAX) ? file_offset : file_offset + 32'd1;
    skip_rem_next    = skip_rem;
    chunk_len_next   = chunk_len;
    chunk_tag_next   = chunk_tag;
    width_r_next     = width_r;
    height_r_next    = height_r;
    colour_next      = colour;
    emit_c           = 1'b0;
    status_c         = ST_OK;
    chans_c          = 3'd0;
    xoff_c           = 32'd0;
    xlen_c           = 32'd0;

    case (phase)
      PH_SIG: begin
        if (data_byte != PNG_MAGIC[idx[2:0]]) begin
          emit_c   = 1'b1;
          status_c = ST_BAD_SIG;
        end else if (idx >= 4'd7) begin
          idx_next   = 4'd0;
          phase_next = PH_IHDR_LEN;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_IHDR_LEN: begin
        chunk_len_next = len_shift;
        if (idx >= 4'd3) begin
          idx_next = 4'd0;
          if (len_shift != IHDR_DATA_LEN) begin
            emit_c   = 1'b1;
            status_c = ST_BAD_LEN;
          end else begin
            phase_next = PH_IHDR_TYPE;
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_IHDR_TYPE: begin
        chunk_tag_next = type_shift;
        if (idx >= 4'd3) begin
          idx_next = 4'd0;
          if (type_shift != TAG_IHDR) begin
            emit_c   = 1'b1;
            status_c = ST_NOT_IHDR;
          end else begin
            phase_next = PH_IHDR_DATA;
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_IHDR_DATA: begin
        if (idx < 4'd4) begin
          width_r_next = {width_r[23:0], data_byte};
        end else if (idx < 4'd8) begin
          height_r_next = {height_r[23:0], data_byte};
        end else if (idx == IHDR_COLOUR_IDX) begin
          colour_next = data_byte;
        end
        if (idx >= IHDR_LAST_IDX) begin
          idx_next      = 4'd0;
          skip_rem_next = CRC_LEN;
          phase_next    = PH_SKIP;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_SKIP: begin
        skip_rem_next = skip_dec;
        if (skip_dec == 33'd0) begin
          idx_next   = 4'd0;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        chunk_len_next = len_shift;
        if (idx >= 4'd3) begin
          idx_next   = 4'd0;
          phase_next = PH_TYPE;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_TYPE: begin
        chunk_tag_next = type_shift;
        if (idx >= 4'd3) begin
          idx_next = 4'd0;
          if (type_shift == TAG_EXIF || type_shift == TAG_IEND) begin
            emit_c  = 1'b1;
            chans_c = channels_of(colour, count_alpha);
            if (chans_c == 3'd0) begin
              status_c = ST_BAD_COLOUR;
            end else if (type_shift == TAG_EXIF) begin
              status_c = ST_EXIF;
              xoff_c   = file_offset_next;
              xlen_c   = chunk_len;
            end else begin
              status_c = ST_OK;
            end
          end else begin
            skip_rem_next = {1'b0, chunk_len} + CRC_LEN;
            phase_next    = PH_SKIP;
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      default: begin
        phase_next = PH_SIG;
        idx_next   = 4'd0;
      end
    endcase

    // A final byte that settles nothing still closes the file.
    if (!emit_c && last_byte) begin
      emit_c   = 1'b1;
      status_c = (phase_next == PH_SIG) ? ST_BAD_SIG : ST_TRUNC;
    end
    if (status_c != ST_OK && status_c != ST_EXIF) begin
      chans_c = 3'd0;
      xoff_c  = 32'd0;
      xlen_c  = 32'd0;
    end
  end

  assign emit              = step && !sent && emit_c;
  assign res.status        = status_c;
  assign res.image_width   = width_r_next;
  assign res.image_height  = height_r_next;
  assign res.colour_kind   = colour_next;
  assign res.channel_count = chans_c;
  assign res.exif_offset   = xoff_c;
  assign res.exif_length   = xlen_c;

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase       <= PH_SIG;
      idx         <= 4'd0;
      file_offset <= 32'd0;
      skip_rem    <= 33'd0;
      chunk_len   <= 32'd0;
      chunk_tag   <= 32'd0;
      width_r     <= 32'd0;
      height_r    <= 32'd0;
      colour      <= 8'd0;
      sent        <= 1'b0;
    end else if (step && !sent) begin
      phase       <= phase_next;
      idx         <= idx_next;
      file_offset <= file_offset_next;
      skip_rem    <= skip_rem_next;
      chunk_len   <= chunk_len_next;
      chunk_tag   <= chunk_tag_next;
      width_r     <= width_r_next;
      height_r    <= height_r_next;
      colour      <= colour_next;
      sent        <= emit_c;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> phase == PH_SIG && idx == 4'd0 && !sent && file_offset == 32'd0)
    else $error("final byte did not return the scanner to start of file");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_rem != 33'd0)
    else $error("skip phase entered with nothing to skip");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    sent |-> !emit)
    else $error("second result for the same file");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    emit && res.status != ST_OK && res.status != ST_EXIF |->
      res.channel_count == 3'd0 && res.exif_offset == 32'd0 && res.exif_length == 32'd0)
    else $error("error result carries channel or eXIf fields");

endmodule

@@ hw/rtl/png_header_chunk_scanner_unit.sv @@
// PNG chunk header scanner: top level with configuration and result register.
//
// Feed a PNG file on file_bytes one byte per transfer, with last_byte set on
// the final byte. The block checks the signature, requires IHDR with length
// 13 first, keeps width, height and colour type, then skips chunk bodies and
// CRCs until an eXIf or IEND type is seen. Each file produces exactly one
// transfer on scan_result; bytes after the deciding one are taken and dropped
// until last_byte, which rearms the block for the next file.
// Throughput: one byte per cycle while no stalled result holds the output register.
// The result is valid in the cycle after the deciding byte's transfer.
// A result waiting in the output register blocks new bytes only while the
// sink stalls it; bytes are accepted when that register is empty or draining.
// cfg_wr_en/cfg_wr_data set count_alpha (reset 1); write it between files.
// Reset (rst, synchronous) returns the scanner to start of file and empties
// the output register.
module png_header_chunk_scanner_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  pngcs_in_if.sink   file_bytes,
  pngcs_out_if.source scan_result
);
  import pngcs_pkg::*;

  logic         count_alpha;
  logic         step;
  logic         emit;
  scan_result_t res;
  scan_result_t res_q;
  logic         out_valid;

  assign file_bytes.ready = !out_valid || scan_result.ready;
  assign step = file_bytes.valid && file_bytes.ready;

  pngcs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (file_bytes.data_byte),
    .last_byte   (file_bytes.last_byte),
    .count_alpha (count_alpha),
    .emit        (emit),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_alpha <= 1'b1;
    end else if (cfg_wr_en) begin
      count_alpha <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (scan_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset; load only with a new result.
  always_ff @(posedge clk) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign scan_result.valid         = out_valid;
  assign scan_result.status        = res_q.status;
  assign scan_result.image_width   = res_q.image_width;
  assign scan_result.image_height  = res_q.image_height;
  assign scan_result.colour_kind   = res_q.colour_kind;
  assign scan_result.channel_count = res_q.channel_count;
  assign scan_result.exif_offset   = res_q.exif_offset;
  assign scan_result.exif_length   = res_q.exif_length;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || scan_result.ready)
    else $error("result register overwritten while stalled");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> scan_result.valid)
    else $error("result not presented after the deciding byte");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !scan_result.ready |-> !step)
    else $error("byte taken while a stalled result holds the output");

endmodule

@@ tb/png_header_chunk_scanner_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the PNG chunk header scanner: random PNG-like files, scoreboard of scan results.
module png_header_chunk_scanner_unit_tb;
  import pngcs_pkg::*;

  // PNG colour types
  localparam logic [7:0] CT_GRAY       = 8'd0;
  localparam logic [7:0] CT_RGB        = 8'd2;
  localparam logic [7:0] CT_PALETTE    = 8'd3;
  localparam logic [7:0] CT_GRAY_ALPHA = 8'd4;
  localparam logic [7:0] CT_RGBA       = 8'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  pngcs_in_if  byte_ch ();
  pngcs_out_if res_ch ();

  png_header_chunk_scanner_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .file_bytes  (byte_ch.sink),
    .scan_result (res_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  file_byte_t   byte_q[$];
  file_byte_t   offered;
  logic [7:0]   file_buf[$];
  scan_result_t expected_results[$];
  int           tx_idle_pct;
  int           rx_idle_pct;
  logic         rx_hold;
  logic         byte_taken;
  int           bytes_accepted;
  int           bytes_queued;
  int           fails;

  // Scanner state as predicted
  logic        sc_alpha;
  logic [2:0]  sc_phase;
  logic [3:0]  sc_idx;
  logic [31:0] sc_offset;
  logic [32:0] sc_skip;
  logic [31:0] sc_len;
  logic [31:0] sc_tag;
  logic [31:0] sc_width;
  logic [31:0] sc_height;
  logic [7:0]  sc_colour;
  logic        sc_done;

  task automatic scan_clear();
    sc_phase  = PH_SIG;
    sc_idx    = '0;
    sc_offset = '0;
    sc_skip   = '0;
    sc_len    = '0;
    sc_tag    = '0;
    sc_width  = '0;
    sc_height = '0;
    sc_colour = '0;
    sc_done   = 1'b0;
  endtask

  function automatic logic [2:0] channels_for(input logic [7:0] kind, input logic alpha);
    logic [2:0] n;
    case (kind)
      CT_GRAY:             n = 3'd1;
      CT_GRAY_ALPHA:       n = alpha ? 3'd2 : 3'd1;
      CT_RGB, CT_PALETTE:  n = 3'd3;
      CT_RGBA:             n = alpha ? 3'd4 : 3'd3;
      default:             n = 3'd0;
    endcase
    return n;
  endfunction

  // Advance the predicted scanner by one byte; queue the result it decides.
  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic         emit;
    logic [2:0]   st;
    logic [2:0]   chans;
    logic [31:0]  xoff;
    logic [31:0]  xlen;
    scan_result_t r;
    emit  = 1'b0;
    st    = ST_OK;
    chans = '0;
    xoff  = '0;
    xlen  = '0;
    if (sc_done) begin
      if (last) scan_clear();
      return;
    end
    if (sc_offset != OFFSET_MAX) sc_offset++;
    case (sc_phase)
      PH_SIG: begin
        if (b != PNG_MAGIC[sc_idx[2:0]]) begin
          emit = 1'b1;
          st   = ST_BAD_SIG;
        end else if (sc_idx >= 4'd7) begin
          sc_idx   = '0;
          sc_phase = PH_IHDR_LEN;
        end else begin
          sc_idx++;
        end
      end
      PH_IHDR_LEN: begin
        sc_len = {sc_len[23:0], b};
        if (sc_idx >= 4'd3) begin
          sc_idx = '0;
          if (sc_len != IHDR_DATA_LEN) begin
            emit = 1'b1;
            st   = ST_BAD_LEN;
          end else begin
            sc_phase = PH_IHDR_TYPE;
          end
        end else begin
          sc_idx++;
        end
      end
      PH_IHDR_TYPE: begin
        sc_tag = {sc_tag[23:0], b};
        if (sc_idx >= 4'd3) begin
          sc_idx = '0;
          if (sc_tag != TAG_IHDR) begin
            emit = 1'b1;
            st   = ST_NOT_IHDR;
          end else begin
            sc_phase = PH_IHDR_DATA;
          end
        end else begin
          sc_idx++;
        end
      end
      PH_IHDR_DATA: begin
        if (sc_idx < 4'd4) sc_width = {sc_width[23:0], b};
        else if (sc_idx < 4'd8) sc_height = {sc_height[23:0], b};
        else if (sc_idx == IHDR_COLOUR_IDX) sc_colour = b;
        if (sc_idx >= IHDR_LAST_IDX) begin
          sc_idx   = '0;
          sc_skip  = CRC_LEN;
          sc_phase = PH_SKIP;
        end else begin
          sc_idx++;
        end
      end
      PH_SKIP: begin
        if (sc_skip != 0) sc_skip--;
        if (sc_skip == 0) begin
          sc_idx   = '0;
          sc_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        sc_len = {sc_len[23:0], b};
        if (sc_idx >= 4'd3) begin
          sc_idx   = '0;
          sc_phase = PH_TYPE;
        end else begin
          sc_idx++;
        end
      end
      PH_TYPE: begin
        sc_tag = {sc_tag[23:0], b};
        if (sc_idx >= 4'd3) begin
          sc_idx = '0;
          if (sc_tag == TAG_EXIF || sc_tag == TAG_IEND) begin
            emit  = 1'b1;
            chans = channels_for(sc_colour, sc_alpha);
            if (chans == 0) begin
              st = ST_BAD_COLOUR;
            end else if (sc_tag == TAG_EXIF) begin
              st   = ST_EXIF;
              xoff = sc_offset;
              xlen = sc_len;
            end else begin
              st = ST_OK;
            end
          end else begin
            sc_skip  = {1'b0, sc_len} + CRC_LEN;
            sc_phase = PH_SKIP;
          end
        end else begin
          sc_idx++;
        end
      end
      default: begin
        sc_phase = PH_SIG;
        sc_idx   = '0;
      end
    endcase
    if (!emit && last) begin
      emit = 1'b1;
      st   = (sc_phase == PH_SIG) ? ST_BAD_SIG : ST_TRUNC;
    end
    if (st != ST_OK && st != ST_EXIF) begin
      chans = '0;
      xoff  = '0;
      xlen  = '0;
    end
    if (emit) begin
      r.status        = st;
      r.image_width   = sc_width;
      r.image_height  = sc_height;
      r.colour_kind   = sc_colour;
      r.channel_count = chans;
      r.exif_offset   = xoff;
      r.exif_length   = xlen;
      expected_results.push_back(r);
      sc_done = 1'b1;
    end
    if (last) scan_clear();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_result();
    scan_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected scan result with status %0d", res_ch.status);
      fails++;
      return;
    end
    e = expected_results.pop_front();
    check_field("status", 32'(e.status), 32'(res_ch.status));
    check_field("image_width", e.image_width, res_ch.image_width);
    check_field("image_height", e.image_height, res_ch.image_height);
    check_field("colour_kind", 32'(e.colour_kind), 32'(res_ch.colour_kind));
    check_field("channel_count", 32'(e.channel_count), 32'(res_ch.channel_count));
    check_field("exif_offset", e.exif_offset, res_ch.exif_offset);
    check_field("exif_length", e.exif_length, res_ch.exif_length);
  endtask

  // Byte driver: hold the offered byte until its transfer, then maybe idle.
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offered = byte_q.pop_front();
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= offered.data;
        byte_ch.last_byte <= offered.last;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || rx_hold) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: predict on each byte transfer, check each result transfer.
  always @(posedge clk) begin
    byte_taken = 1'b0;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        byte_taken = 1'b1;
        bytes_accepted++;
        scan_byte(byte_ch.data_byte, byte_ch.last_byte);
      end
      if (res_ch.valid && res_ch.ready) check_result();
    end
  end

  // Long receiver stall while the sender keeps offering bytes.
  initial begin
    rx_hold = 1'b0;
    while (bytes_accepted < 650) @(posedge clk);
    rx_hold = 1'b1;
    repeat (150) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'h0;
    if (pick == 1) return 32'hFFFF_FFFF;
    if (pick < 5) return $urandom_range(4096);
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_colour();
    case ($urandom_range(6))
      0: return CT_GRAY;
      1: return CT_RGB;
      2: return CT_PALETTE;
      3: return CT_GRAY_ALPHA;
      4: return CT_RGBA;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_word(input logic [31:0] w);
    file_buf.push_back(w[31:24]);
    file_buf.push_back(w[23:16]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[7:0]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) file_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_sig();
    for (int i = 0; i < $size(PNG_MAGIC); i++) file_buf.push_back(PNG_MAGIC[i]);
  endtask

  // IHDR chunk with random bit depth, methods and CRC.
  task automatic put_ihdr(input logic [31:0] w, input logic [31:0] h,
                          input logic [7:0] colour);
    put_word(IHDR_DATA_LEN);
    put_word(TAG_IHDR);
    put_word(w);
    put_word(h);
    put_rand(1);
    file_buf.push_back(colour);
    put_rand(3 + 4);
  endtask

  // Full file: signature, IHDR, some ancillary chunks, then the header of the
  // final chunk and a few trailing bytes that the scanner drops.
  task automatic put_png(input logic [31:0] w, input logic [31:0] h, input logic [7:0] colour,
                         input int extras, input logic [31:0] final_tag,
                         input logic [31:0] final_len, input int trail);
    int n;
    put_sig();
    put_ihdr(w, h, colour);
    repeat (extras) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      put_word(n);
      put_word($urandom);
      put_rand(n + 4);
    end
    put_word(final_len);
    put_word(final_tag);
    put_rand(trail);
  endtask

  // Move the assembled file to the byte queue, marking its final byte.
  task automatic send_file();
    file_byte_t fb;
    foreach (file_buf[i]) begin
      fb.data = file_buf[i];
      fb.last = (i == file_buf.size() - 1);
      byte_q.push_back(fb);
    end
    bytes_queued += file_buf.size();
    file_buf.delete();
  endtask

  task automatic random_file();
    int pick;
    int n;
    put_png(rand_word(), rand_word(), rand_colour(), $urandom_range(2),
            $urandom_range(1) ? TAG_EXIF : TAG_IEND, rand_word(), $urandom_range(3));
    pick = $urandom_range(99);
    if (pick >= 70 && pick < 80) begin
      n = $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > n) void'(file_buf.pop_back());
    end else if (pick >= 80 && pick < 90) begin
      n = $urandom_range(file_buf.size() - 1);
      file_buf[n] = file_buf[n] ^ (8'h01 << $urandom_range(7));
    end else if (pick >= 90 && pick < 95) begin
      file_buf.delete();
      put_rand($urandom_range(1, 12));
    end else if (pick >= 95) begin
      // chunk usually too long to finish skipping
      file_buf.delete();
      put_sig();
      put_ihdr(rand_word(), rand_word(), rand_colour());
      put_word($urandom_range(1) ? 32'hFFFF_FFFF : rand_word());
      put_word($urandom);
      put_rand($urandom_range(20));
    end
    send_file();
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct);
    int start;
    int files;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = bytes_queued;
    files = 0;
    while (bytes_queued - start < 150 || files < 3) begin
      random_file();
      files++;
    end
  endtask

  task automatic wait_idle();
    while (!(byte_q.size() == 0 && !byte_ch.valid && expected_results.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_alpha(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sc_alpha = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    res_ch.ready      = 1'b0;
    byte_taken        = 1'b0;
    bytes_accepted    = 0;
    bytes_queued      = 0;
    fails             = 0;
    tx_idle_pct       = 21;
    rx_idle_pct       = 70;
    sc_alpha          = 1'b1;
    scan_clear();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // wrong first byte, one-byte file
    file_buf.push_back(8'h00);
    send_file();
    // file ends inside a matching signature
    file_buf.push_back(PNG_MAGIC[0]);
    send_file();
    // signature differs at the fourth byte, rest dropped
    put_sig();
    file_buf[3] = 8'hFF;
    send_file();
    // complete signature only
    put_sig();
    send_file();
    // IHDR length wrong
    put_sig();
    put_word(IHDR_DATA_LEN + 1);
    put_word(TAG_IHDR);
    send_file();
    // first chunk is not IHDR
    put_sig();
    put_word(IHDR_DATA_LEN);
    put_word(TAG_IHDR ^ 32'h1);
    put_rand(2);
    send_file();
    put_png(32'hFFFF_FFFF, 32'h0, CT_GRAY, 0, TAG_IEND, 32'h0, 0);
    send_file();
    put_png(32'h0, 32'hFFFF_FFFF, CT_RGBA, 1, TAG_EXIF, 32'hFFFF_FFFF, 3);
    send_file();
    put_png(32'd1, 32'd1, 8'hFF, 0, TAG_IEND, 32'h0, 1);
    send_file();
    put_png(32'd640, 32'd480, CT_GRAY_ALPHA, 2, TAG_EXIF, 32'd100, 2);
    send_file();
    put_png(32'd7, 32'd9, CT_PALETTE, 1, TAG_IEND, 32'h0, 0);
    send_file();
    put_png(32'd33, 32'd44, CT_RGB, 0, TAG_EXIF, 32'd12, 0);
    send_file();
    // truncated while skipping a chunk body
    put_sig();
    put_ihdr(32'd5, 32'd6, CT_RGB);
    put_word(32'd20);
    put_word(32'h7445_5874);
    put_rand(5);
    send_file();
    // maximum chunk length, skip never completes
    put_sig();
    put_ihdr(32'd8, 32'd8, CT_RGBA);
    put_word(32'hFFFF_FFFF);
    put_word(32'h7445_5874);
    put_rand(6);
    send_file();
    wait_idle();

    write_alpha(1'b0);
    put_png(32'd2, 32'd3, CT_GRAY_ALPHA, 0, TAG_IEND, 32'h0, 0);
    send_file();
    put_png(32'd4, 32'd5, CT_RGBA, 1, TAG_EXIF, 32'd64, 1);
    send_file();
    wait_idle();

    write_alpha(1'b1);
    random_phase(21, 70);
    wait_idle();
    write_alpha(1'b0);
    random_phase(70, 21);
    wait_idle();
    write_alpha(1'b1);
    random_phase(0, 0);
    wait_idle();
    repeat (10) @(posedge clk);

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
